/* rtl/mfua_pkg.sv */
// types and constants for the unit-augmenting max-flow engine
// no dependencies; imported by max_flow_unit_augment_core
package mfua_pkg;

	localparam int NODE_W = 6;
	localparam int CAPF_W = 16;
	localparam int FLOW_W = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SINK   = 1'd1;

	localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

	typedef struct packed {
		logic [1:0]        operation;
		logic [NODE_W-1:0] row_node;
		logic [NODE_W-1:0] col_node;
		logic [CAPF_W-1:0] capacity;
	} cmd_t;

	typedef struct packed {
		logic [CAPF_W-1:0] read_value;
		logic [FLOW_W-1:0] total_flow;
	} rsp_t;

endpackage

/* rtl/max_flow_unit_augment_core.sv */
// unit-augmenting max-flow engine (edmonds-karp) over a residual matrix
// depends on mfua_pkg for the command/response beats and codes
//
// usage
//  - command beat: cmd is taken at a rising edge with start high and busy low
//  - response beat: exactly one per command, on rsp for one cycle with done high;
//    the receiver cannot stall, so there is no backpressure on rsp
//  - config: cfg_valid/cfg_ready with cfg_index (0 source, 1 sink) and cfg_data;
//    cfg_ready is always high; writes must come only while the engine is idle,
//    which the block itself does not enforce
//  - write capacity: done in the next cycle, busy stays low, one write per cycle
//  - read residual: matrix read registered, S_RD gives done; busy for one cycle
//  - clear: one matrix entry zeroed per cycle over all 2^(2*clog2(NODES))
//    entries (4096 by default), then done
//  - run: each search dequeues a node through S_DEQ and S_DEQW, then scans its
//    neighbours 0 to sink, one matrix read per cycle; each augment step walks
//    S_AUG_PAR, S_AUG_PW, S_AUG_FWD, S_AUG_REV; the run ends on a failed search
// reset
//  - arst_n clears control state, then a clearing pass of the same length as
//    clear zeroes the matrix; busy is high during it and no response is given
module max_flow_unit_augment_core #(
	parameter int NODES    = 64,
	parameter int CAP_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  mfua_pkg::cmd_t              cmd,
	output logic                        done,
	output mfua_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mfua_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfua_pkg::NODE_W-1:0] cfg_data
);
	import mfua_pkg::*;

	localparam int NB = $clog2(NODES);
	localparam int AW = 2 * NB;
	localparam int QW = NB + 1;
	localparam logic [CAP_BITS-1:0] CAP_MAX = '1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_BFS, S_DEQ, S_DEQW, S_SCAN,
		S_AUG_PAR, S_AUG_PW, S_AUG_FWD, S_AUG_REV
	} state_t;

	state_t state_q;

	// residual matrix, row-major with padded rows
	logic [CAP_BITS-1:0] residual_mem [2**AW];
	logic [CAP_BITS-1:0] mem_rd_q;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [CAP_BITS-1:0] mem_wdata;

	// bfs parent and queue stores, never cleared
	logic [NB-1:0] parent_mem [NODES];
	logic [NB-1:0] queue_mem  [NODES];
	logic [NB-1:0] par_rd_q, q_rd_q;
	logic          par_we, q_we;
	logic [NB-1:0] par_waddr, par_wdata, par_raddr;
	logic [NB-1:0] q_waddr, q_wdata, q_raddr;

	logic [NODE_W-1:0] src_q, sink_q;
	logic [NODES-1:0]  visited_q;
	logic [QW-1:0]     head_q, tail_q, guard_q;
	logic [NB-1:0]     u_q, v_q, node_q, p_q;
	logic              iss_q;
	logic              chk_vld_s1;
	logic [NB-1:0]     chk_v_s1;
	logic [AW-1:0]     clr_addr_q;
	logic              clr_report_q;
	logic              rd_ok_q;
	logic [FLOW_W-1:0] total_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic [NB-1:0] src_idx, sink_idx, row_idx, col_idx;
	logic          ends_ok, edge_ok, accept, hit, q_room;

	assign src_idx  = NB'(src_q);
	assign sink_idx = NB'(sink_q);
	assign row_idx  = NB'(cmd.row_node);
	assign col_idx  = NB'(cmd.col_node);
	assign ends_ok  = (32'(src_q) < NODES) && (32'(sink_q) < NODES);
	assign edge_ok  = (32'(cmd.row_node) < NODES) && (32'(cmd.col_node) < NODES);
	assign accept   = start && (state_q == S_IDLE);
	assign q_room   = 32'(tail_q) < NODES;
	// a neighbour with residual left that the search has not seen yet
	assign hit      = chk_vld_s1 && (mem_rd_q != '0) && !visited_q[chk_v_s1];

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// matrix, parent and queue port control: one read and one write address per cycle each
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		par_we    = 1'b0;
		par_waddr = chk_v_s1;
		par_wdata = u_q;
		par_raddr = node_q;
		q_we      = 1'b0;
		q_waddr   = tail_q[NB-1:0];
		q_wdata   = chk_v_s1;
		q_raddr   = head_q[NB-1:0];
		unique case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
			end
			S_IDLE: begin
				mem_raddr = {row_idx, col_idx};
				if (accept && cmd.operation == OP_WRITE && edge_ok) begin
					mem_we    = 1'b1;
					mem_waddr = {row_idx, col_idx};
					mem_wdata = CAP_BITS'(cmd.capacity);
				end
			end
			S_BFS: begin
				q_we    = 1'b1;
				q_waddr = '0;
				q_wdata = src_idx;
			end
			S_SCAN: begin
				mem_raddr = {u_q, v_q};
				par_we    = hit;
				q_we      = hit && q_room;
			end
			S_AUG_PW: begin
				mem_raddr = {par_rd_q, node_q};
			end
			S_AUG_FWD: begin
				// forward residual down by one unless already empty
				mem_raddr = {node_q, p_q};
				mem_we    = (mem_rd_q != '0);
				mem_waddr = {p_q, node_q};
				mem_wdata = mem_rd_q - CAP_BITS'(1);
			end
			S_AUG_REV: begin
				// reverse residual up by one, saturating
				mem_we    = (mem_rd_q != CAP_MAX);
				mem_waddr = {node_q, p_q};
				mem_wdata = mem_rd_q + CAP_BITS'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			residual_mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q <= residual_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			parent_mem[par_waddr] <= par_wdata;
		end
		par_rd_q <= parent_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_waddr] <= q_wdata;
		end
		q_rd_q <= queue_mem[q_raddr];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= '0;
			sink_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOURCE: src_q  <= cfg_data;
				REG_SINK:   sink_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer with registered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_addr_q   <= '0;
			clr_report_q <= 1'b0;
			visited_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			guard_q      <= '0;
			iss_q        <= 1'b0;
			chk_vld_s1   <= 1'b0;
			total_q      <= '0;
			done_q       <= 1'b0;
			rd_ok_q      <= 1'b0;
			rsp_q        <= '0;
			u_q          <= '0;
			v_q          <= '0;
			node_q       <= '0;
			p_q          <= '0;
			chk_v_s1     <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					// only a host clear reports, not the pass after reset
					done_q     <= (clr_addr_q == '1) && clr_report_q;
					if (clr_addr_q == '1) begin
						state_q <= S_IDLE;
						if (clr_report_q) begin
							rsp_q <= '0;
						end
						clr_report_q <= 1'b0;
					end
				end
				S_IDLE: begin
					// writes and runs with bad ends answer right away
					done_q <= accept && (cmd.operation == OP_WRITE ||
						(cmd.operation == OP_RUN && !ends_ok));
					if (accept) begin
						unique case (cmd.operation)
							OP_WRITE: begin
								rsp_q <= '0;
							end
							OP_READ: begin
								rd_ok_q <= edge_ok;
								state_q <= S_RD;
							end
							OP_RUN: begin
								total_q <= '0;
								if (ends_ok) begin
									state_q <= S_BFS;
								end else begin
									rsp_q <= '0;
								end
							end
							OP_CLEAR: begin
								clr_addr_q   <= '0;
								clr_report_q <= 1'b1;
								state_q      <= S_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					done_q  <= 1'b1;
					rsp_q   <= '{read_value: rd_ok_q ? CAPF_W'(mem_rd_q) : CAPF_W'(0),
						total_flow: FLOW_W'(0)};
					state_q <= S_IDLE;
				end
				S_BFS: begin
					done_q    <= 1'b0;
					visited_q <= NODES'(1) << src_idx;
					head_q    <= '0;
					tail_q    <= QW'(1);
					state_q   <= S_DEQ;
				end
				S_DEQ: begin
					done_q <= (head_q == tail_q);
					if (head_q == tail_q) begin
						// search failed: run is over
						rsp_q   <= '{read_value: '0, total_flow: total_q};
						state_q <= S_IDLE;
					end else begin
						head_q  <= head_q + QW'(1);
						state_q <= S_DEQW;
					end
				end
				S_DEQW: begin
					done_q     <= 1'b0;
					u_q        <= q_rd_q;
					v_q        <= '0;
					iss_q      <= 1'b1;
					chk_vld_s1 <= 1'b0;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					done_q   <= 1'b0;
					chk_v_s1 <= v_q;
					if (hit) begin
						visited_q[chk_v_s1] <= 1'b1;
						if (q_room) begin
							tail_q <= tail_q + QW'(1);
						end
					end
					if (hit && chk_v_s1 == sink_idx) begin
						node_q     <= sink_idx;
						guard_q    <= '0;
						iss_q      <= 1'b0;
						chk_vld_s1 <= 1'b0;
						state_q    <= S_AUG_PAR;
					end else begin
						chk_vld_s1 <= iss_q;
						if (iss_q) begin
							if (v_q == sink_idx) begin
								iss_q <= 1'b0;
							end else begin
								v_q <= v_q + NB'(1);
							end
						end
						if (!iss_q && !chk_vld_s1) begin
							state_q <= S_DEQ;
						end
					end
				end
				S_AUG_PAR: begin
					done_q  <= 1'b0;
					state_q <= S_AUG_PW;
				end
				S_AUG_PW: begin
					done_q  <= 1'b0;
					p_q     <= par_rd_q;
					state_q <= S_AUG_FWD;
				end
				S_AUG_FWD: begin
					done_q  <= 1'b0;
					state_q <= S_AUG_REV;
				end
				S_AUG_REV: begin
					done_q  <= 1'b0;
					node_q  <= p_q;
					guard_q <= guard_q + QW'(1);
					if (p_q == src_idx || 32'(guard_q) + 1 >= NODES) begin
						if (total_q != FLOW_MAX) begin
							total_q <= total_q + FLOW_W'(1);
						end
						state_q <= S_BFS;
					end else begin
						state_q <= S_AUG_PAR;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the source stays marked for the whole of a search
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> visited_q[src_idx])
		else $error("source not marked during scan");

	// queue never grows past the node count
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(tail_q) <= NODES)
		else $error("search queue overrun");

	// a response never carries both a read value and a flow count
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.read_value != '0) |-> (rsp_q.total_flow == '0))
		else $error("mixed response fields");

	// a new command is only taken from idle, so done follows no scan directly
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> !done_q)
		else $error("response during scan");

endmodule
